FILE: src/smfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfs_pkg
// Shared types, register codes, reset values and saturating helpers for the
// smoothed sponge fold step unit.
// ----------------------------------------------------------------------------
package smfs_pkg;

   localparam int FRAC_BITS_DEFAULT = 32;
   localparam int ROOT_STEPS        = 64;
   localparam int CSR_INDEX_W       = 3;

   localparam int MODE_SQRT_BIT = 0;
   localparam int MODE_ABS_BIT  = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE,
      CSR_SQRT_OFFSET,
      CSR_ABS_OFFSET,
      CSR_SMOOTH_OFFSET,
      CSR_SCALE,
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_CENTER_Z
   } csr_index_type;

   localparam logic [1:0]         MODE_RST          = 2'd0;
   localparam logic [62:0]        SQRT_OFFSET_RST   = 63'd0;
   localparam logic signed [63:0] ABS_OFFSET_RST    = 64'sd0;
   localparam logic [62:0]        SMOOTH_OFFSET_RST = 63'd21474836;
   localparam logic signed [63:0] SCALE_RST         = 64'sd12884901888;
   localparam logic signed [63:0] CENTER_X_RST      = 64'sd8589934592;
   localparam logic signed [63:0] CENTER_Y_RST      = 64'sd8589934592;
   localparam logic signed [63:0] CENTER_Z_RST      = 64'sd4294967296;

   // floor(n / 3) = (n * DIV3_MAGIC) >> 65 for any 64-bit n
   localparam logic [63:0] DIV3_MAGIC = 64'hAAAA_AAAA_AAAA_AAAB;

   localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

   typedef struct packed {
      logic signed [63:0] px;
      logic signed [63:0] py;
      logic signed [63:0] pz;
      logic signed [63:0] pw;
      logic [62:0]        de_in;
   } req_type;

   typedef struct packed {
      logic signed [63:0] qx;
      logic signed [63:0] qy;
      logic signed [63:0] qz;
      logic signed [63:0] qw;
      logic [62:0]        de_out;
   } rsp_type;

   function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         sat_add = s[64] ? SAT_MIN : SAT_MAX;
      end else begin
         sat_add = s[63:0];
      end
   endfunction

   function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         sat_sub = s[64] ? SAT_MIN : SAT_MAX;
      end else begin
         sat_sub = s[63:0];
      end
   endfunction

   function automatic logic signed [63:0] sat_abs(logic signed [63:0] a);
      if (a == SAT_MIN) begin
         sat_abs = SAT_MAX;
      end else begin
         sat_abs = a[63] ? -a : a;
      end
   endfunction

   function automatic logic [63:0] mag64(logic signed [63:0] a);
      mag64 = a[63] ? 64'(-a) : 64'(a);
   endfunction

endpackage

FILE: src/smfs_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfs_mul
// Pipelined unsigned 64x64 -> 128 multiplier, three stages, from 32x32
// partial products. Lanes share one valid and one sideband word.
// ----------------------------------------------------------------------------
module smfs_mul #(
   parameter int LANES = 1,
   parameter int PW    = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [LANES-1:0][63:0]  in_a,
   input  logic [LANES-1:0][63:0]  in_b,
   input  logic [PW-1:0]           in_pl,
   output logic                    out_valid,
   output logic [LANES-1:0][127:0] out_prod,
   output logic [PW-1:0]           out_pl
);

   logic [2:0]                    valid_ff;
   logic [LANES-1:0][63:0]        p00_ff, p01_ff, p10_ff, p11_ff;
   logic [LANES-1:0][127:0]       cat_ff;
   logic [LANES-1:0][64:0]        mid_ff;
   logic [LANES-1:0][127:0]       prod_ff;
   logic [PW-1:0]                 pl_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            p00_ff[l]  <= 64'(in_a[l][31:0])  * 64'(in_b[l][31:0]);
            p01_ff[l]  <= 64'(in_a[l][31:0])  * 64'(in_b[l][63:32]);
            p10_ff[l]  <= 64'(in_a[l][63:32]) * 64'(in_b[l][31:0]);
            p11_ff[l]  <= 64'(in_a[l][63:32]) * 64'(in_b[l][63:32]);
            cat_ff[l]  <= {p11_ff[l], p00_ff[l]};
            mid_ff[l]  <= 65'(p01_ff[l]) + 65'(p10_ff[l]);
            prod_ff[l] <= cat_ff[l] + (128'(mid_ff[l]) << 32);
         end
         pl_ff[0] <= in_pl;
         pl_ff[1] <= pl_ff[0];
         pl_ff[2] <= pl_ff[1];
      end
   end

   assign out_valid = valid_ff[2];
   assign out_prod  = prod_ff;
   assign out_pl    = pl_ff[2];

endmodule

FILE: src/smfs_softroot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfs_softroot
// Pipelined floor(sqrt(v^2 + off * 2^F)) per lane, saturated to 2^63-1.
// Magnitude, square, offset add, then one result bit per stage.
// ----------------------------------------------------------------------------
module smfs_softroot #(
   parameter int LANES     = 1,
   parameter int PW        = 1,
   parameter int FRAC_BITS = smfs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [LANES-1:0][63:0] in_v,
   input  logic [62:0]            in_off,
   input  logic [PW-1:0]          in_pl,
   output logic                   out_valid,
   output logic [LANES-1:0][63:0] out_root,
   output logic [PW-1:0]          out_pl
);

   localparam int STEPS = smfs_pkg::ROOT_STEPS;
   localparam int RW    = 2 * STEPS;
   localparam int REM_W = STEPS + 1;

   logic                    mag_valid_ff;
   logic [LANES-1:0][63:0]  mag_ff;
   logic [PW-1:0]           mag_pl_ff;

   logic                    sq_valid;
   logic [LANES-1:0][127:0] sq_prod;
   logic [PW-1:0]           sq_pl;

   logic                          st_valid_ff [STEPS+1];
   logic [LANES-1:0][RW-1:0]      rad_ff      [STEPS+1];
   logic [LANES-1:0][REM_W-1:0]   rem_ff      [STEPS+1];
   logic [LANES-1:0][STEPS-1:0]   root_ff     [STEPS+1];
   logic [PW-1:0]                 pl_ff       [STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
      end else if (advance) begin
         mag_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            mag_ff[l] <= smfs_pkg::mag64(in_v[l]);
         end
         mag_pl_ff <= in_pl;
      end
   end

   smfs_mul #(
      .LANES (LANES),
      .PW    (PW)
   ) u_square (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (mag_valid_ff),
      .in_a      (mag_ff),
      .in_b      (mag_ff),
      .in_pl     (mag_pl_ff),
      .out_valid (sq_valid),
      .out_prod  (sq_prod),
      .out_pl    (sq_pl)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         st_valid_ff[0] <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            rad_ff[0][l]  <= RW'(sq_prod[l]) + (RW'(in_off) << FRAC_BITS);
            rem_ff[0][l]  <= '0;
            root_ff[0][l] <= '0;
         end
         pl_ff[0] <= sq_pl;
      end
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [LANES-1:0][REM_W+1:0]  rem2;
      logic [LANES-1:0][REM_W+1:0]  trial;
      logic [LANES-1:0][REM_W-1:0]  rem_in;
      logic [LANES-1:0][STEPS-1:0]  root_in;
      logic [LANES-1:0][RW-1:0]     rad_in;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            rem2[l]   = {rem_ff[j][l], rad_ff[j][l][RW-1 -: 2]};
            trial[l]  = (REM_W+2)'({root_ff[j][l], 2'b01});
            rad_in[l] = rad_ff[j][l] << 2;
            if (rem2[l] >= trial[l]) begin
               rem_in[l]  = REM_W'(rem2[l] - trial[l]);
               root_in[l] = {root_ff[j][l][STEPS-2:0], 1'b1};
            end else begin
               rem_in[l]  = REM_W'(rem2[l]);
               root_in[l] = {root_ff[j][l][STEPS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[j+1] <= 1'b0;
         end else if (advance) begin
            st_valid_ff[j+1] <= st_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j+1]  <= rem_in;
            root_ff[j+1] <= root_in;
            rad_ff[j+1]  <= rad_in;
            pl_ff[j+1]   <= pl_ff[j];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_root[l] = root_ff[STEPS][l][STEPS-1] ? 64'(smfs_pkg::SAT_MAX)
                                                  : 64'(root_ff[STEPS][l]);
      end
   end

   assign out_valid = st_valid_ff[STEPS];
   assign out_pl    = pl_ff[STEPS];

endmodule

FILE: src/smooth_menger_fold_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_menger_fold_step_unit
// One smoothed sponge fold iteration on a Q-format point and DE factor.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: valid/ready input channel, one point per item (req_data).
//   rsp_*: valid/ready result channel, one result item per input item,
//          in input order.
//   csr_*: register write port; write only while no item is in flight.
// Structure: five chained square roots (prefold, three soft sorts, z fold),
//   each one result bit per stage behind a three-stage 64x64 multiplier.
// Throughput: one item per cycle while the pipeline is not stalled.
// Stall: the whole pipeline holds while the output register is full and
//   not taken and the last stage is occupied; empty slots still move up,
//   so req_ready stays high while a result waits behind an empty stage.
// Reset: clears all valid bits and loads register defaults; the z center
//   divided by three is refreshed through the divide multiplier after reset or a write.
// ----------------------------------------------------------------------------
module smooth_menger_fold_step_unit #(
   parameter int FRAC_BITS = smfs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  smfs_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output smfs_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [smfs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                        csr_wdata
);

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
      logic signed [63:0] w;
      logic [62:0]        de;
   } pt_type;

   typedef struct packed {
      pt_type             p;
      logic signed [63:0] t;
   } sort_pl_type;

   typedef struct packed {
      logic [2:0]         neg;
      logic signed [63:0] w;
   } fin_pl_type;

   localparam int PT_W   = $bits(pt_type);
   localparam int SORT_W = $bits(sort_pl_type);
   localparam int FIN_W  = $bits(fin_pl_type);

   function automatic logic signed [63:0] get_a(pt_type p, int k);
      get_a = (k == 2) ? p.y : p.x;
   endfunction

   function automatic logic signed [63:0] get_b(pt_type p, int k);
      get_b = (k == 0) ? p.y : p.z;
   endfunction

   function automatic pt_type put_ab(pt_type p, int k, logic signed [63:0] a,
                                     logic signed [63:0] b);
      pt_type r;
      r = p;
      if (k == 2) begin
         r.y = a;
      end else begin
         r.x = a;
      end
      if (k == 0) begin
         r.y = b;
      end else begin
         r.z = b;
      end
      put_ab = r;
   endfunction

   // ---------------- configuration ----------------
   logic [1:0]         mode_ff;
   logic [62:0]        sqrt_off_ff;
   logic signed [63:0] abs_off_ff;
   logic [62:0]        smooth_off_ff;
   logic signed [63:0] scale_ff;
   logic signed [63:0] cx_ff;
   logic signed [63:0] cy_ff;
   logic signed [63:0] cz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= smfs_pkg::MODE_RST;
         sqrt_off_ff   <= smfs_pkg::SQRT_OFFSET_RST;
         abs_off_ff    <= smfs_pkg::ABS_OFFSET_RST;
         smooth_off_ff <= smfs_pkg::SMOOTH_OFFSET_RST;
         scale_ff      <= smfs_pkg::SCALE_RST;
         cx_ff         <= smfs_pkg::CENTER_X_RST;
         cy_ff         <= smfs_pkg::CENTER_Y_RST;
         cz_ff         <= smfs_pkg::CENTER_Z_RST;
      end else if (csr_we) begin
         unique case (smfs_pkg::csr_index_type'(csr_index))
            smfs_pkg::CSR_MODE:          mode_ff       <= csr_wdata[1:0];
            smfs_pkg::CSR_SQRT_OFFSET:   sqrt_off_ff   <= csr_wdata[62:0];
            smfs_pkg::CSR_ABS_OFFSET:    abs_off_ff    <= csr_wdata;
            smfs_pkg::CSR_SMOOTH_OFFSET: smooth_off_ff <= csr_wdata[62:0];
            smfs_pkg::CSR_SCALE:         scale_ff      <= csr_wdata;
            smfs_pkg::CSR_CENTER_X:      cx_ff         <= csr_wdata;
            smfs_pkg::CSR_CENTER_Y:      cy_ff         <= csr_wdata;
            smfs_pkg::CSR_CENTER_Z:      cz_ff         <= csr_wdata;
         endcase
      end
   end

   // center_z / 3, truncated toward zero, refreshed continuously
   logic                  d3_valid;
   logic [0:0][127:0]     d3_prod;
   logic                  d3_neg;
   logic [63:0]           d3_q;
   logic signed [63:0]    c_ff;

   smfs_mul #(
      .LANES (1),
      .PW    (1)
   ) u_div3 (
      .clock     (clock),
      .reset     (reset),
      .advance   (1'b1),
      .in_valid  (1'b1),
      .in_a      (smfs_pkg::mag64(cz_ff)),
      .in_b      (smfs_pkg::DIV3_MAGIC),
      .in_pl     (cz_ff[63]),
      .out_valid (d3_valid),
      .out_prod  (d3_prod),
      .out_pl    (d3_neg)
   );

   assign d3_q = 64'(d3_prod[0][127:65]);

   always_ff @(posedge clock) begin
      if (d3_valid) begin
         c_ff <= d3_neg ? -d3_q : d3_q;
      end
   end

   // ---------------- flow control ----------------
   logic    advance;
   logic    f1_valid_ff;
   logic    rsp_valid_ff;
   logic    rsp_load;

   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign advance   = rsp_load || !f1_valid_ff;
   assign req_ready = advance;

   // ---------------- input stage ----------------
   logic    s0_valid_ff;
   pt_type  s0_pt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_pt_ff <= '{x: req_data.px, y: req_data.py, z: req_data.pz,
                       w: req_data.pw, de: req_data.de_in};
      end
   end

   // ---------------- pre-folds ----------------
   logic                pre_valid;
   logic [2:0][63:0]    pre_root;
   pt_type              pre_pl;

   smfs_softroot #(
      .LANES     (3),
      .PW        (PT_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_pre_root (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_v      ({s0_pt_ff.z, s0_pt_ff.y, s0_pt_ff.x}),
      .in_off    (sqrt_off_ff),
      .in_pl     (s0_pt_ff),
      .out_valid (pre_valid),
      .out_root  (pre_root),
      .out_pl    (pre_pl)
   );

   logic    a_valid_ff;
   pt_type  a_pt_ff;
   pt_type  a_pt_in;
   logic    b_valid_ff;
   pt_type  b_pt_ff;
   pt_type  b_pt_in;

   always_comb begin
      a_pt_in = pre_pl;
      if (mode_ff[smfs_pkg::MODE_SQRT_BIT]) begin
         a_pt_in.x = pre_root[0];
         a_pt_in.y = pre_root[1];
         a_pt_in.z = pre_root[2];
      end
      if (mode_ff[smfs_pkg::MODE_ABS_BIT]) begin
         a_pt_in.x = smfs_pkg::sat_abs(a_pt_in.x);
         a_pt_in.y = smfs_pkg::sat_abs(a_pt_in.y);
         a_pt_in.z = smfs_pkg::sat_abs(a_pt_in.z);
         a_pt_in.w = smfs_pkg::sat_abs(a_pt_in.w);
      end
   end

   always_comb begin
      b_pt_in = a_pt_ff;
      if (mode_ff[smfs_pkg::MODE_ABS_BIT]) begin
         b_pt_in.x = smfs_pkg::sat_add(a_pt_ff.x, abs_off_ff);
         b_pt_in.y = smfs_pkg::sat_add(a_pt_ff.y, abs_off_ff);
         b_pt_in.z = smfs_pkg::sat_add(a_pt_ff.z, abs_off_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= pre_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_pt_ff <= a_pt_in;
         b_pt_ff <= b_pt_in;
      end
   end

   // ---------------- soft sorts: (x,y), (x,z), (y,z) ----------------
   logic    srt_valid [4];
   pt_type  srt_pt    [4];

   assign srt_valid[0] = b_valid_ff;
   assign srt_pt[0]    = b_pt_ff;

   for (genvar k = 0; k < 3; k++) begin : g_sort
      logic                t_valid_ff;
      sort_pl_type         t_pl_ff;
      logic                r_valid;
      logic [0:0][63:0]    r_root;
      sort_pl_type         r_pl;
      logic [63:0]         diff;
      logic                m_valid_ff;
      logic signed [63:0]  m_ff;
      pt_type              m_pt_ff;
      logic                u_valid_ff;
      pt_type              u_pt_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            t_valid_ff <= 1'b0;
         end else if (advance) begin
            t_valid_ff <= srt_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            t_pl_ff.p <= srt_pt[k];
            t_pl_ff.t <= smfs_pkg::sat_sub(get_a(srt_pt[k], k), get_b(srt_pt[k], k));
         end
      end

      smfs_softroot #(
         .LANES     (1),
         .PW        (SORT_W),
         .FRAC_BITS (FRAC_BITS)
      ) u_root (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (t_valid_ff),
         .in_v      (t_pl_ff.t),
         .in_off    (smooth_off_ff),
         .in_pl     (t_pl_ff),
         .out_valid (r_valid),
         .out_root  (r_root),
         .out_pl    (r_pl)
      );

      assign diff = r_root[0] - 64'(r_pl.t);

      always_ff @(posedge clock) begin
         if (reset) begin
            m_valid_ff <= 1'b0;
            u_valid_ff <= 1'b0;
         end else if (advance) begin
            m_valid_ff <= r_valid;
            u_valid_ff <= m_valid_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            m_ff    <= {1'b0, diff[63:1]};
            m_pt_ff <= r_pl.p;
            u_pt_ff <= put_ab(m_pt_ff, k,
                              smfs_pkg::sat_add(get_a(m_pt_ff, k), m_ff),
                              smfs_pkg::sat_sub(get_b(m_pt_ff, k), m_ff));
         end
      end

      assign srt_valid[k+1] = u_valid_ff;
      assign srt_pt[k+1]    = u_pt_ff;
   end

   // ---------------- soft negative fold of z ----------------
   logic                z1_valid_ff;
   pt_type              z1_pt_ff;
   pt_type              z1_pt_in;
   logic                zr_valid;
   logic [0:0][63:0]    zr_root;
   pt_type              zr_pl;
   logic                z2_valid_ff;
   pt_type              z2_pt_ff;
   pt_type              z2_pt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         z1_valid_ff <= 1'b0;
      end else if (advance) begin
         z1_valid_ff <= srt_valid[3];
      end
   end

   always_comb begin
      z1_pt_in   = srt_pt[3];
      z1_pt_in.z = smfs_pkg::sat_sub(srt_pt[3].z, c_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z1_pt_ff <= z1_pt_in;
      end
   end

   smfs_softroot #(
      .LANES     (1),
      .PW        (PT_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_zroot (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (z1_valid_ff),
      .in_v      (z1_pt_ff.z),
      .in_off    (smooth_off_ff),
      .in_pl     (z1_pt_ff),
      .out_valid (zr_valid),
      .out_root  (zr_root),
      .out_pl    (zr_pl)
   );

   always_comb begin
      z2_pt_in   = zr_pl;
      z2_pt_in.z = smfs_pkg::sat_add(-$signed(zr_root[0]), c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z2_valid_ff <= 1'b0;
      end else if (advance) begin
         z2_valid_ff <= zr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z2_pt_ff <= z2_pt_in;
      end
   end

   // ---------------- scale, shift, DE ----------------
   logic                f0_valid_ff;
   logic [3:0][63:0]    f0_mag_ff;
   fin_pl_type          f0_pl_ff;
   logic [63:0]         scale_mag;
   logic                fm_valid;
   logic [3:0][127:0]   fm_prod;
   fin_pl_type          fm_pl;
   logic [3:0][127:0]   fm_sh;
   logic signed [63:0]  f1_x_ff, f1_y_ff, f1_z_ff, f1_w_ff;
   logic [62:0]         f1_de_ff;
   logic signed [63:0]  f1_q_in [3];
   logic [62:0]         f1_de_in;

   assign scale_mag = smfs_pkg::mag64(scale_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
      end else if (advance) begin
         f0_valid_ff <= z2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f0_mag_ff[0] <= smfs_pkg::mag64(z2_pt_ff.x);
         f0_mag_ff[1] <= smfs_pkg::mag64(z2_pt_ff.y);
         f0_mag_ff[2] <= smfs_pkg::mag64(z2_pt_ff.z);
         f0_mag_ff[3] <= 64'(z2_pt_ff.de);
         f0_pl_ff.neg <= {z2_pt_ff.z[63] != scale_ff[63],
                          z2_pt_ff.y[63] != scale_ff[63],
                          z2_pt_ff.x[63] != scale_ff[63]};
         f0_pl_ff.w   <= z2_pt_ff.w;
      end
   end

   smfs_mul #(
      .LANES (4),
      .PW    (FIN_W)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f0_valid_ff),
      .in_a      ({scale_mag, scale_mag, scale_mag, scale_mag}),
      .in_b      (f0_mag_ff),
      .in_pl     (f0_pl_ff),
      .out_valid (fm_valid),
      .out_prod  (fm_prod),
      .out_pl    (fm_pl)
   );

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         fm_sh[l] = fm_prod[l] >> FRAC_BITS;
      end
      for (int l = 0; l < 3; l++) begin
         if (fm_pl.neg[l]) begin
            if ((|fm_sh[l][127:64]) || (fm_sh[l][63:0] > 64'(smfs_pkg::SAT_MIN))) begin
               f1_q_in[l] = smfs_pkg::SAT_MIN;
            end else begin
               f1_q_in[l] = -$signed(fm_sh[l][63:0]);
            end
         end else if ((|fm_sh[l][127:64]) || fm_sh[l][63]) begin
            f1_q_in[l] = smfs_pkg::SAT_MAX;
         end else begin
            f1_q_in[l] = fm_sh[l][63:0];
         end
      end
      if ((|fm_sh[3][127:64]) || fm_sh[3][63]) begin
         f1_de_in = {63{1'b1}};
      end else begin
         f1_de_in = fm_sh[3][62:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= fm_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_x_ff  <= f1_q_in[0];
         f1_y_ff  <= f1_q_in[1];
         f1_z_ff  <= f1_q_in[2];
         f1_w_ff  <= fm_pl.w;
         f1_de_ff <= f1_de_in;
      end
   end

   // ---------------- output register ----------------
   smfs_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.qx     <= smfs_pkg::sat_sub(f1_x_ff, cx_ff);
         rsp_data_ff.qy     <= smfs_pkg::sat_sub(f1_y_ff, cy_ff);
         rsp_data_ff.qz     <= f1_z_ff;
         rsp_data_ff.qw     <= f1_w_ff;
         rsp_data_ff.de_out <= f1_de_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_ready_when_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input blocked while output is being taken");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while output register is empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
